@@ hw/rtl/hcrc_pkg.sv @@
package hcrc_pkg;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_RELAY  = 2'd1,
    OP_BUZZER = 2'd2
  } opcode_t;

  localparam logic [2:0] CFG_AUTO_MODE     = 3'd0;
  localparam logic [2:0] CFG_SUMMER_MODE   = 3'd1;
  localparam logic [2:0] CFG_SAFE_MODE     = 3'd2;
  localparam logic [2:0] CFG_UPPER_LIMIT   = 3'd3;
  localparam logic [2:0] CFG_LOWER_LIMIT   = 3'd4;
  localparam logic [2:0] CFG_HUMI_SETPOINT = 3'd5;
  localparam logic [2:0] CFG_HEATER_HOUR   = 3'd6;
  localparam logic [2:0] CFG_HEATER_MINUTE = 3'd7;

  localparam int RLY_CLIMATE  = 0;
  localparam int RLY_HUMIDIFY = 1;
  localparam int RLY_HEATER   = 2;
  localparam int RLY_LIGHT    = 3;

  localparam logic [9:0] BEEP_NONE    = 10'd0;
  localparam logic [9:0] BEEP_ALARM   = 10'd500;
  localparam logic [9:0] BEEP_COMMAND = 10'd1000;

  localparam logic signed [8:0] HUMI_BAND = 9'sd5;

  typedef struct packed {
    logic       auto_mode;
    logic       summer_mode;
    logic       safe_mode;
    logic [7:0] upper_limit;
    logic [7:0] lower_limit;
    logic [6:0] humi_setpoint;
    logic [4:0] heater_hour;
    logic [5:0] heater_minute;
  } cfg_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] temp_reading;
    logic [6:0] humi_reading;
    logic       reading_valid;
    logic [4:0] clock_hour;
    logic [5:0] clock_minute;
    logic       occupied;
    logic [1:0] relay_index;
    logic       relay_on;
  } item_t;

  typedef struct packed {
    logic [3:0] relays;
    logic [7:0] held_temp;
    logic [6:0] held_humi;
  } state_t;

  typedef struct packed {
    state_t     st;
    logic [9:0] beep_ms;
    logic       settings_rejected;
  } result_t;

endpackage

@@ hw/rtl/hcrc_cfg_regs.sv @@
module hcrc_cfg_regs
  import hcrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  output cfg_t       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_AUTO_MODE:     cfg.auto_mode     <= cfg_data[0];
        CFG_SUMMER_MODE:   cfg.summer_mode   <= cfg_data[0];
        CFG_SAFE_MODE:     cfg.safe_mode     <= cfg_data[0];
        CFG_UPPER_LIMIT:   cfg.upper_limit   <= cfg_data;
        CFG_LOWER_LIMIT:   cfg.lower_limit   <= cfg_data;
        CFG_HUMI_SETPOINT: cfg.humi_setpoint <= cfg_data[6:0];
        CFG_HEATER_HOUR:   cfg.heater_hour   <= cfg_data[4:0];
        CFG_HEATER_MINUTE: cfg.heater_minute <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/hcrc_rules.sv @@
module hcrc_rules
  import hcrc_pkg::*;
(
  input  item_t   item,
  input  cfg_t    cfg,
  input  state_t  st,
  output result_t res
);

  logic              limits_ok;
  logic signed [8:0] hv;
  logic signed [8:0] sp;
  logic [5:0]        hour_after;
  state_t            st_next;
  logic [9:0]        beep;

  assign limits_ok  = cfg.upper_limit > cfg.lower_limit;
  assign sp         = $signed({2'b00, cfg.humi_setpoint});
  assign hour_after = {1'b0, cfg.heater_hour} + 6'd1;

  always_comb begin
    st_next = st;
    beep    = BEEP_NONE;
    if (item.opcode == OP_TICK && item.reading_valid) begin
      st_next.held_temp = item.temp_reading;
      st_next.held_humi = item.humi_reading;
    end
    hv = $signed({2'b00, st_next.held_humi});
    unique case (item.opcode)
      OP_TICK: begin
        if (cfg.auto_mode) begin
          if (!limits_ok) begin
            st_next.relays[RLY_CLIMATE] = 1'b0;
          end else if (st_next.held_temp >= cfg.upper_limit) begin
            st_next.relays[RLY_CLIMATE] = cfg.summer_mode;
          end else if (st_next.held_temp <= cfg.lower_limit) begin
            st_next.relays[RLY_CLIMATE] = !cfg.summer_mode;
          end else begin
            st_next.relays[RLY_CLIMATE] = 1'b0;
          end
          if (hv < sp - HUMI_BAND) st_next.relays[RLY_HUMIDIFY] = 1'b1;
          if (hv > sp + HUMI_BAND) st_next.relays[RLY_HUMIDIFY] = 1'b0;
          if (item.clock_hour == cfg.heater_hour) begin
            st_next.relays[RLY_HEATER] = item.clock_minute >= cfg.heater_minute;
          end
          if ({1'b0, item.clock_hour} == hour_after) begin
            st_next.relays[RLY_HEATER] = item.clock_minute <= cfg.heater_minute;
          end
          st_next.relays[RLY_LIGHT] = item.occupied;
          if (cfg.safe_mode && item.occupied) beep = BEEP_ALARM;
        end else if (cfg.safe_mode) begin
          st_next.relays[RLY_LIGHT] = item.occupied;
          if (item.occupied) beep = BEEP_ALARM;
        end
      end
      OP_RELAY: begin
        st_next.relays[item.relay_index] = item.relay_on;
      end
      OP_BUZZER: begin
        if (item.relay_on) beep = BEEP_COMMAND;
      end
      default: ;
    endcase
  end

  assign res.st                = st_next;
  assign res.beep_ms           = beep;
  assign res.settings_rejected = !cfg.auto_mode || !limits_ok;

endmodule

@@ hw/rtl/home_climate_relay_controller_core.sv @@
// Relay controller for a home climate unit: sensor ticks, manual relay commands and buzzer
// commands enter on the input channel, and each transfer yields exactly one result with the
// four relay states, the beep request, the held samples and the settings flag. An item is
// held in the input register, the rules are evaluated in one combinational pass against
// the relay and sample state, and the result is captured in the output register while the
// state is updated; one item per cycle is sustained while out_stall is low, and out_valid
// is registered when the held item advances into the output register. The input
// side keeps accepting while a result waits, until both the input and output registers are
// full. Configuration writes take effect at once and are meant to be made while no item is
// in flight.
module home_climate_relay_controller_core
  import hcrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] opcode,
  input  logic [7:0] temp_reading,
  input  logic [6:0] humi_reading,
  input  logic       reading_valid,
  input  logic [4:0] clock_hour,
  input  logic [5:0] clock_minute,
  input  logic       occupied,
  input  logic [1:0] relay_index,
  input  logic       relay_on,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       climate_relay,
  output logic       humidifier_relay,
  output logic       water_heater_relay,
  output logic       light_relay,
  output logic [9:0] beep_ms,
  output logic [7:0] temp_value,
  output logic [6:0] humi_value,
  output logic       settings_rejected
);

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  state_t  st;
  result_t res;
  result_t out_res;
  logic    advance;

  hcrc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hcrc_rules u_rules (
    .item (item),
    .cfg  (cfg),
    .st   (st),
    .res  (res)
  );

  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= '{opcode, temp_reading, humi_reading, reading_valid, clock_hour,
                clock_minute, occupied, relay_index, relay_on};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= res.st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign climate_relay      = out_res.st.relays[RLY_CLIMATE];
  assign humidifier_relay   = out_res.st.relays[RLY_HUMIDIFY];
  assign water_heater_relay = out_res.st.relays[RLY_HEATER];
  assign light_relay        = out_res.st.relays[RLY_LIGHT];
  assign beep_ms            = out_res.beep_ms;
  assign temp_value         = out_res.st.held_temp;
  assign humi_value         = out_res.st.held_humi;
  assign settings_rejected  = out_res.settings_rejected;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> item_valid && out_valid && out_stall)
    else $error("input stalled without a full pipeline");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result register not loaded after advance");

  a_out_tracks_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_res.st == st)
    else $error("pending result disagrees with relay state");

  a_buzzer_no_alarm: assert property (@(posedge clk) disable iff (rst)
    advance && item.opcode == OP_BUZZER |=> beep_ms != BEEP_ALARM)
    else $error("buzzer command produced alarm beep");

endmodule

@@ tb/tb_home_climate_relay_controller_core.sv @@
`timescale 1ns / 100ps

module tb_home_climate_relay_controller_core;
  import hcrc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 75;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic       out_valid;
  logic       out_stall;
  logic       climate_relay;
  logic       humidifier_relay;
  logic       water_heater_relay;
  logic       light_relay;
  logic [9:0] beep_ms;
  logic [7:0] temp_value;
  logic [6:0] humi_value;
  logic       settings_rejected;

  item_t   drive_item;
  item_t   items_to_send[$];
  result_t status_due[$];
  state_t  relay_mirror;
  cfg_t    settings_mirror;

  bit took;
  bit gaps_on;
  bit stalls_on;
  int gap_left;
  int stall_left;
  int errors;
  int cycles;

  home_climate_relay_controller_core dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .opcode            (drive_item.opcode),
    .temp_reading      (drive_item.temp_reading),
    .humi_reading      (drive_item.humi_reading),
    .reading_valid     (drive_item.reading_valid),
    .clock_hour        (drive_item.clock_hour),
    .clock_minute      (drive_item.clock_minute),
    .occupied          (drive_item.occupied),
    .relay_index       (drive_item.relay_index),
    .relay_on          (drive_item.relay_on),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .climate_relay     (climate_relay),
    .humidifier_relay  (humidifier_relay),
    .water_heater_relay(water_heater_relay),
    .light_relay       (light_relay),
    .beep_ms           (beep_ms),
    .temp_value        (temp_value),
    .humi_value        (humi_value),
    .settings_rejected (settings_rejected)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic result_t next_status(item_t it);
    result_t r;
    logic    limits_ok;
    int      hv;
    int      sp;
    r.beep_ms = BEEP_NONE;
    limits_ok = settings_mirror.upper_limit > settings_mirror.lower_limit;
    case (it.opcode)
      OP_TICK: begin
        if (it.reading_valid) begin
          relay_mirror.held_temp = it.temp_reading;
          relay_mirror.held_humi = it.humi_reading;
        end
        if (settings_mirror.auto_mode) begin
          hv = int'(relay_mirror.held_humi);
          sp = int'(settings_mirror.humi_setpoint);
          if (!limits_ok) begin
            relay_mirror.relays[RLY_CLIMATE] = 1'b0;
          end else if (relay_mirror.held_temp >= settings_mirror.upper_limit) begin
            relay_mirror.relays[RLY_CLIMATE] = settings_mirror.summer_mode;
          end else if (relay_mirror.held_temp <= settings_mirror.lower_limit) begin
            relay_mirror.relays[RLY_CLIMATE] = !settings_mirror.summer_mode;
          end else begin
            relay_mirror.relays[RLY_CLIMATE] = 1'b0;
          end
          if (hv < sp - int'(HUMI_BAND)) relay_mirror.relays[RLY_HUMIDIFY] = 1'b1;
          if (hv > sp + int'(HUMI_BAND)) relay_mirror.relays[RLY_HUMIDIFY] = 1'b0;
          if (int'(it.clock_hour) == int'(settings_mirror.heater_hour))
            relay_mirror.relays[RLY_HEATER] = it.clock_minute >= settings_mirror.heater_minute;
          if (int'(it.clock_hour) == int'(settings_mirror.heater_hour) + 1)
            relay_mirror.relays[RLY_HEATER] = it.clock_minute <= settings_mirror.heater_minute;
          relay_mirror.relays[RLY_LIGHT] = it.occupied;
          if (settings_mirror.safe_mode && it.occupied) r.beep_ms = BEEP_ALARM;
        end else if (settings_mirror.safe_mode) begin
          relay_mirror.relays[RLY_LIGHT] = it.occupied;
          if (it.occupied) r.beep_ms = BEEP_ALARM;
        end
      end
      OP_RELAY: begin
        relay_mirror.relays[it.relay_index] = it.relay_on;
      end
      OP_BUZZER: begin
        if (it.relay_on) r.beep_ms = BEEP_COMMAND;
      end
      default: begin
      end
    endcase
    r.st = relay_mirror;
    r.settings_rejected = !settings_mirror.auto_mode || !limits_ok;
    return r;
  endfunction

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int near(int center, int spread, int hi);
    int v;
    v = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic item_t tick(int t, int h, bit v, int hr, int mn, bit occ);
    item_t it;
    it.opcode        = OP_TICK;
    it.temp_reading  = 8'(t);
    it.humi_reading  = 7'(h);
    it.reading_valid = v;
    it.clock_hour    = 5'(hr);
    it.clock_minute  = 6'(mn);
    it.occupied      = occ;
    it.relay_index   = 2'($urandom);
    it.relay_on      = 1'($urandom);
    return it;
  endfunction

  function automatic item_t command(logic [1:0] op, int idx, bit on);
    item_t it;
    it = tick($urandom_range(0, 255), $urandom_range(0, 100), 1'($urandom),
              $urandom_range(0, 23), $urandom_range(0, 59), 1'($urandom));
    it.opcode      = op;
    it.relay_index = 2'(idx);
    it.relay_on    = on;
    return it;
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int    r;
    int    t;
    int    h;
    int    hr;
    int    mn;
    case ($urandom_range(0, 2))
      0: t = near(int'(settings_mirror.upper_limit), 2, 255);
      1: t = near(int'(settings_mirror.lower_limit), 2, 255);
      default: t = $urandom_range(0, 255);
    endcase
    r = $urandom_range(0, 99);
    if (r < 60) h = near(int'(settings_mirror.humi_setpoint), 7, 100);
    else if (r < 97) h = $urandom_range(0, 100);
    else h = $urandom_range(0, 127);
    r = $urandom_range(0, 19);
    if (r < 6) hr = int'(settings_mirror.heater_hour);
    else if (r < 12) hr = near(int'(settings_mirror.heater_hour) + 1, 0, 31);
    else if (r < 19) hr = $urandom_range(0, 23);
    else hr = $urandom_range(0, 31);
    r = $urandom_range(0, 19);
    if (r < 10) mn = near(int'(settings_mirror.heater_minute), 1, 63);
    else if (r < 19) mn = $urandom_range(0, 59);
    else mn = $urandom_range(0, 63);
    it = tick(t, h, $urandom_range(0, 5) != 0, hr, mn, 1'($urandom));
    r = $urandom_range(0, 99);
    if (r < 62) it.opcode = OP_TICK;
    else if (r < 85) it.opcode = OP_RELAY;
    else if (r < 95) it.opcode = OP_BUZZER;
    else it.opcode = OP_UNUSED;
    return it;
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    int   lo;
    c.auto_mode   = $urandom_range(0, 3) != 0;
    c.summer_mode = 1'($urandom);
    c.safe_mode   = 1'($urandom);
    lo = $urandom_range(0, 200);
    case ($urandom_range(0, 5))
      0: begin
        c.upper_limit = 8'd255;
        c.lower_limit = 8'd0;
      end
      1: begin
        c.upper_limit = 8'(lo);
        c.lower_limit = 8'(lo);
      end
      2: begin
        c.upper_limit = 8'($urandom);
        c.lower_limit = 8'($urandom);
      end
      default: begin
        c.lower_limit = 8'(lo);
        c.upper_limit = 8'(lo + int'($urandom_range(1, 55)));
      end
    endcase
    case ($urandom_range(0, 5))
      0: c.humi_setpoint = 7'($urandom_range(0, 4));
      1: c.humi_setpoint = 7'($urandom_range(101, 127));
      default: c.humi_setpoint = 7'($urandom_range(5, 100));
    endcase
    case ($urandom_range(0, 9))
      0, 1: c.heater_hour = 5'd23;
      2: c.heater_hour = 5'd0;
      3: c.heater_hour = 5'($urandom_range(24, 31));
      default: c.heater_hour = 5'($urandom_range(0, 23));
    endcase
    case ($urandom_range(0, 7))
      0: c.heater_minute = 6'd0;
      1: c.heater_minute = 6'd59;
      2: c.heater_minute = 6'($urandom_range(60, 63));
      default: c.heater_minute = 6'($urandom_range(0, 59));
    endcase
    return c;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [7:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_AUTO_MODE:     settings_mirror.auto_mode     = data[0];
      CFG_SUMMER_MODE:   settings_mirror.summer_mode   = data[0];
      CFG_SAFE_MODE:     settings_mirror.safe_mode     = data[0];
      CFG_UPPER_LIMIT:   settings_mirror.upper_limit   = data;
      CFG_LOWER_LIMIT:   settings_mirror.lower_limit   = data;
      CFG_HUMI_SETPOINT: settings_mirror.humi_setpoint = data[6:0];
      CFG_HEATER_HOUR:   settings_mirror.heater_hour   = data[4:0];
      CFG_HEATER_MINUTE: settings_mirror.heater_minute = data[5:0];
      default: begin
      end
    endcase
  endtask

  task automatic load_settings(cfg_t c);
    logic [7:0] junk;
    junk = 8'($urandom);
    write_reg(CFG_AUTO_MODE, {junk[7:1], c.auto_mode});
    junk = 8'($urandom);
    write_reg(CFG_SUMMER_MODE, {junk[7:1], c.summer_mode});
    junk = 8'($urandom);
    write_reg(CFG_SAFE_MODE, {junk[7:1], c.safe_mode});
    write_reg(CFG_UPPER_LIMIT, c.upper_limit);
    write_reg(CFG_LOWER_LIMIT, c.lower_limit);
    junk = 8'($urandom);
    write_reg(CFG_HUMI_SETPOINT, {junk[7], c.humi_setpoint});
    junk = 8'($urandom);
    write_reg(CFG_HEATER_HOUR, {junk[7:5], c.heater_hour});
    junk = 8'($urandom);
    write_reg(CFG_HEATER_MINUTE, {junk[7:6], c.heater_minute});
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic settle();
    do @(posedge clk);
    while (items_to_send.size() != 0 || in_valid || status_due.size() != 0);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // sender: hold the payload until the transfer, then advance
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (items_to_send.size() > 0) begin
        drive_item <= items_to_send.pop_front();
        in_valid <= 1'b1;
        if (gaps_on && $urandom_range(0, 3) == 0) gap_left = pick_pause();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (stalls_on && $urandom_range(0, 3) == 0) begin
      stall_left = pick_pause() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    result_t want;
    took = !rst && in_valid && !in_stall;
    if (took) status_due.push_back(next_status(drive_item));
    if (!rst && out_valid && !out_stall) begin
      if (status_due.size() == 0) begin
        errors++;
        $display("%0t: result transfer with nothing expected", $time);
      end else begin
        want = status_due.pop_front();
        check_field("climate_relay", int'(want.st.relays[RLY_CLIMATE]),
                    int'(climate_relay));
        check_field("humidifier_relay", int'(want.st.relays[RLY_HUMIDIFY]),
                    int'(humidifier_relay));
        check_field("water_heater_relay", int'(want.st.relays[RLY_HEATER]),
                    int'(water_heater_relay));
        check_field("light_relay", int'(want.st.relays[RLY_LIGHT]), int'(light_relay));
        check_field("beep_ms", int'(want.beep_ms), int'(beep_ms));
        check_field("temp_value", int'(want.st.held_temp), int'(temp_value));
        check_field("humi_value", int'(want.st.held_humi), int'(humi_value));
        check_field("settings_rejected", int'(want.settings_rejected),
                    int'(settings_rejected));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    cfg_t c;
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    out_stall  = 1'b0;
    drive_item = '0;
    relay_mirror    = '0;
    settings_mirror = '0;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // manual mode: latch samples, direct relay control, buzzer and unused opcode
    items_to_send.push_back(tick(255, 100, 1'b1, 23, 59, 1'b1));
    items_to_send.push_back(tick(0, 0, 1'b0, 0, 0, 1'b0));
    for (int i = 0; i < 4; i++) items_to_send.push_back(command(OP_RELAY, i, 1'b1));
    items_to_send.push_back(command(OP_RELAY, RLY_LIGHT, 1'b0));
    items_to_send.push_back(command(OP_BUZZER, $urandom_range(0, 3), 1'b1));
    items_to_send.push_back(command(OP_BUZZER, $urandom_range(0, 3), 1'b0));
    items_to_send.push_back(command(OP_UNUSED, $urandom_range(0, 3), 1'b1));
    settle();

    c = settings_mirror;
    c.safe_mode = 1'b1;
    load_settings(c);
    items_to_send.push_back(tick(10, 10, 1'b1, 5, 5, 1'b1));
    items_to_send.push_back(tick(10, 10, 1'b1, 5, 5, 1'b0));
    settle();

    // auto rules around the limits, humidity band and heater window past hour 23
    c = '{auto_mode: 1'b1, summer_mode: 1'b1, safe_mode: 1'b1, upper_limit: 8'd30,
          lower_limit: 8'd20, humi_setpoint: 7'd50, heater_hour: 5'd23, heater_minute: 6'd30};
    load_settings(c);
    items_to_send.push_back(tick(35, 40, 1'b1, 23, 30, 1'b1));
    items_to_send.push_back(tick(25, 50, 1'b1, 23, 29, 1'b0));
    items_to_send.push_back(tick(20, 56, 1'b1, 24, 30, 1'b0));
    items_to_send.push_back(tick(30, 55, 1'b1, 24, 31, 1'b0));
    items_to_send.push_back(tick(0, 45, 1'b1, 0, 0, 1'b1));
    items_to_send.push_back(tick(200, 90, 1'b0, 0, 0, 1'b1));
    settle();

    // inconsistent limits and a setpoint below the band
    c = '{auto_mode: 1'b1, summer_mode: 1'b0, safe_mode: 1'b0, upper_limit: 8'd0,
          lower_limit: 8'd255, humi_setpoint: 7'd4, heater_hour: 5'd0, heater_minute: 6'd0};
    load_settings(c);
    items_to_send.push_back(tick(255, 0, 1'b1, 0, 0, 1'b0));
    items_to_send.push_back(tick(0, 100, 1'b1, 1, 0, 1'b1));
    settle();

    c = '{auto_mode: 1'b1, summer_mode: 1'b0, safe_mode: 1'b1, upper_limit: 8'd255,
          lower_limit: 8'd0, humi_setpoint: 7'd127, heater_hour: 5'd31, heater_minute: 6'd63};
    load_settings(c);
    items_to_send.push_back(tick(255, 100, 1'b1, 31, 63, 1'b1));
    items_to_send.push_back(tick(0, 0, 1'b1, 31, 62, 1'b0));
    items_to_send.push_back(tick(128, 121, 1'b1, 12, 0, 1'b1));
    settle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      gaps_on   = (ph % 4) != 1 && (ph % 4) != 3;
      stalls_on = (ph % 4) != 2 && (ph % 4) != 3;
      load_settings(rand_cfg());
      for (int i = 0; i < ITEMS_PER_PHASE; i++) items_to_send.push_back(rand_item());
      settle();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
